FILE: design/aabb_cr_pkg.sv
// Shared types and constants for the box collision resolver.
// Used by aabb_cr_table, aabb_cr_scan and aabb_collision_resolver_top.
package aabb_cr_pkg;

    localparam int S_TDATA_W  = 112;
    localparam int S_TUSER_W  = 1;
    localparam int M_TDATA_W  = 80;
    localparam int M_TUSER_W  = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_ENTRIES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVER_SIZE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OBSTACLE_SIZE  = 2'd2;

    localparam logic [7:0] RST_ACTIVE_ENTRIES = 8'd0;
    localparam logic [7:0] RST_MOVER_SIZE     = 8'd32;
    localparam logic [7:0] RST_OBSTACLE_SIZE  = 8'd64;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_RESOLVE = 1'b1;

    localparam logic AXIS_X = 1'b0;
    localparam logic AXIS_Y = 1'b1;

    localparam logic [1:0] HIT_NONE    = 2'd0;
    localparam logic [1:0] HIT_BLOCK   = 2'd1;
    localparam logic [1:0] HIT_OVERLAP = 2'd2;

    localparam logic signed [1:0] PUSH_ZERO = 2'sb00;
    localparam logic signed [1:0] PUSH_POS  = 2'sb01;
    localparam logic signed [1:0] PUSH_NEG  = 2'sb11;

    typedef struct packed {
        logic [7:0] active_entries;
        logic [7:0] mover_size;
        logic [7:0] obstacle_size;
    } cfg_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               blocks;
        logic               overlaps;
    } entry_t;

    typedef struct packed {
        logic               command;
        logic [6:0]         entry_index;
        entry_t             entry;
        logic signed [15:0] mover_x;
        logic signed [15:0] mover_y;
        logic signed [15:0] speed_x;
        logic signed [15:0] speed_y;
        logic               axis;
    } req_t;

    typedef struct packed {
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic signed [15:0] out_speed_x;
        logic signed [15:0] out_speed_y;
        logic [1:0]         hit_kind;
        logic [6:0]         hit_entry;
        logic signed [1:0]  push_x;
        logic signed [1:0]  push_y;
    } res_t;

    function automatic logic signed [17:0] sx18(input logic signed [15:0] v);
        return $signed({{2{v[15]}}, v});
    endfunction

    function automatic logic signed [17:0] side18(input logic [7:0] s);
        return $signed({6'b0, s, 4'b0});
    endfunction

    function automatic logic signed [17:0] halfside18(input logic [7:0] s);
        return $signed({7'b0, s, 3'b0});
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > 18'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -18'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

FILE: design/aabb_cr_table.sv
// Obstacle table: single-port write, registered read.
// Depends on aabb_cr_pkg for the entry type.
module aabb_cr_table #(
    parameter int TABLE_DEPTH = 128,
    parameter int ADDR_W      = 7
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  aabb_cr_pkg::entry_t  wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_W-1:0]    rd_addr,
    output aabb_cr_pkg::entry_t  rd_data
);
    import aabb_cr_pkg::*;

    entry_t table_mem [TABLE_DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            table_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= table_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/aabb_cr_scan.sv
// Command sequencer: table loads, ordered scan with overlap test, penetration
// and push-out, result register. Depends on aabb_cr_pkg.
module aabb_cr_scan #(
    parameter int TABLE_DEPTH = 128,
    parameter int ADDR_W      = 7
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  aabb_cr_pkg::cfg_t    cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  aabb_cr_pkg::req_t    req,
    output logic                 out_valid,
    input  logic                 out_ready,
    output aabb_cr_pkg::res_t    res,
    output logic                 wr_en,
    output logic [ADDR_W-1:0]    wr_addr,
    output aabb_cr_pkg::entry_t  wr_data,
    output logic                 rd_en,
    output logic [ADDR_W-1:0]    rd_addr,
    input  aabb_cr_pkg::entry_t  rd_data
);
    import aabb_cr_pkg::*;

    localparam int IDX_W = (ADDR_W > 8) ? ADDR_W : 8;
    localparam int CNT_W = IDX_W + 1;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SCAN = 5'b00010,
        ST_DIFF = 5'b00100,
        ST_NORM = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic             rd_vld_reg, rd_vld_next;
    logic [6:0]       rd_tag_reg;
    logic             out_valid_reg, out_valid_next;

    logic signed [15:0] px_reg, py_reg, vx_reg, vy_reg;
    logic               axis_reg;
    logic signed [15:0] ex_reg, ey_reg;
    logic [1:0]         kind_reg;
    logic [6:0]         hit_reg;
    logic signed [18:0] dx_reg, dy_reg;
    logic signed [1:0]  nx_reg, ny_reg;
    logic [12:0]        pen_reg;
    res_t               res_reg;

    logic [CNT_W-1:0]   lim;
    logic [CNT_W-1:0]   active_ext;
    logic               accept, issue, touch, hit_now, out_free;
    logic               entry_ok;
    logic [CNT_W-1:0]   idx_ext;

    logic signed [17:0] px18, py18, ex18, ey18, ms18, os18, mh18, oh18;
    logic signed [17:0] ex_end, ey_end, px_end, py_end;
    logic signed [17:0] cmx, cmy, cex, cey;
    logic signed [18:0] dx_c, dy_c, adx, ady;
    logic [11:0]        half12;
    logic signed [19:0] pen_x, pen_y;
    logic signed [17:0] pen18, push_pos;
    logic signed [15:0] ox, oy, ovx, ovy;

    // accept and table write
    assign in_ready   = (state_reg == ST_IDLE);
    assign accept     = in_valid && in_ready;
    assign idx_ext    = CNT_W'(req.entry_index);
    assign entry_ok   = idx_ext < DEPTH_C;
    assign wr_en      = accept && (req.command == CMD_LOAD) && entry_ok;
    assign wr_addr    = idx_ext[ADDR_W-1:0];
    assign wr_data    = req.entry;

    // scan bound and read issue
    assign active_ext = CNT_W'(cfg.active_entries);
    assign lim        = (active_ext > DEPTH_C) ? DEPTH_C : active_ext;
    assign issue      = (state_reg == ST_SCAN) && (rd_idx_reg < lim);
    assign rd_en      = issue;
    assign rd_addr    = rd_idx_reg[ADDR_W-1:0];

    // overlap test on the word just read
    assign px18   = sx18(px_reg);
    assign py18   = sx18(py_reg);
    assign ex18   = sx18(rd_data.x);
    assign ey18   = sx18(rd_data.y);
    assign ms18   = side18(cfg.mover_size);
    assign os18   = side18(cfg.obstacle_size);
    assign mh18   = halfside18(cfg.mover_size);
    assign oh18   = halfside18(cfg.obstacle_size);
    assign ex_end = ex18 + os18;
    assign ey_end = ey18 + os18;
    assign px_end = px18 + ms18;
    assign py_end = py18 + ms18;
    assign touch  = (px18 < ex_end) && (px_end > ex18) &&
                    (py18 < ey_end) && (py_end > ey18);
    assign hit_now = rd_vld_reg && touch && (rd_data.blocks || rd_data.overlaps);

    // center differences
    assign cmx  = px18 + mh18;
    assign cmy  = py18 + mh18;
    assign cex  = sx18(ex_reg) + oh18;
    assign cey  = sx18(ey_reg) + oh18;
    assign dx_c = $signed({cmx[17], cmx}) - $signed({cex[17], cex});
    assign dy_c = $signed({cmy[17], cmy}) - $signed({cey[17], cey});

    // penetration per axis
    assign half12 = {9'(cfg.mover_size) + 9'(cfg.obstacle_size), 3'b0};
    assign adx    = dx_reg[18] ? -dx_reg : dx_reg;
    assign ady    = dy_reg[18] ? -dy_reg : dy_reg;
    assign pen_x  = $signed({8'b0, half12}) - $signed({adx[18], adx});
    assign pen_y  = $signed({8'b0, half12}) - $signed({ady[18], ady});

    // push-out and velocity clamp
    assign pen18 = $signed({5'b0, pen_reg});
    always_comb begin
        ox  = px_reg;
        oy  = py_reg;
        ovx = vx_reg;
        ovy = vy_reg;
        push_pos = 18'sd0;
        if (kind_reg == HIT_BLOCK) begin
            if (axis_reg == AXIS_X && nx_reg != PUSH_ZERO) begin
                push_pos = (nx_reg == PUSH_POS) ? px18 + pen18 : px18 - pen18;
                ox = sat16(push_pos);
                if ((nx_reg == PUSH_POS && vx_reg < 0) ||
                    (nx_reg == PUSH_NEG && vx_reg > 0)) begin
                    ovx = 16'sd0;
                end
            end else if (axis_reg == AXIS_Y && ny_reg != PUSH_ZERO) begin
                push_pos = (ny_reg == PUSH_POS) ? py18 + pen18 : py18 - pen18;
                oy = sat16(push_pos);
                if ((ny_reg == PUSH_POS && vy_reg < 0) ||
                    (ny_reg == PUSH_NEG && vy_reg > 0)) begin
                    ovy = 16'sd0;
                end
            end
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    always_comb begin
        state_next     = state_reg;
        rd_idx_next    = rd_idx_reg;
        rd_vld_next    = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && req.command == CMD_RESOLVE) begin
                    state_next  = ST_SCAN;
                    rd_idx_next = '0;
                end
            end
            ST_SCAN: begin
                rd_vld_next = issue;
                if (issue) begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                priority if (hit_now) begin
                    state_next  = rd_data.blocks ? ST_DIFF : ST_DONE;
                    rd_vld_next = 1'b0;
                end else if (!issue) begin
                    state_next = ST_DONE;
                end
            end
            ST_DIFF: state_next = ST_NORM;
            ST_NORM: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            rd_idx_reg    <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            rd_idx_reg    <= rd_idx_next;
            rd_vld_reg    <= rd_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_tag_reg <= rd_idx_reg[6:0];
        if (accept && req.command == CMD_RESOLVE) begin
            px_reg   <= req.mover_x;
            py_reg   <= req.mover_y;
            vx_reg   <= req.speed_x;
            vy_reg   <= req.speed_y;
            axis_reg <= req.axis;
            kind_reg <= HIT_NONE;
            hit_reg  <= '0;
            nx_reg   <= PUSH_ZERO;
            ny_reg   <= PUSH_ZERO;
        end
        if (state_reg == ST_SCAN && hit_now) begin
            ex_reg   <= rd_data.x;
            ey_reg   <= rd_data.y;
            hit_reg  <= rd_tag_reg;
            kind_reg <= rd_data.blocks ? HIT_BLOCK : HIT_OVERLAP;
        end
        if (state_reg == ST_DIFF) begin
            dx_reg <= dx_c;
            dy_reg <= dy_c;
        end
        if (state_reg == ST_NORM) begin
            if (pen_x < pen_y) begin
                nx_reg  <= (!dx_reg[18] && dx_reg != 0) ? PUSH_POS : PUSH_NEG;
                pen_reg <= pen_x[12:0];
            end else begin
                ny_reg  <= (!dy_reg[18] && dy_reg != 0) ? PUSH_POS : PUSH_NEG;
                pen_reg <= pen_y[12:0];
            end
        end
        if (state_reg == ST_DONE && out_free) begin
            res_reg.out_x       <= ox;
            res_reg.out_y       <= oy;
            res_reg.out_speed_x <= ovx;
            res_reg.out_speed_y <= ovy;
            res_reg.hit_kind    <= kind_reg;
            res_reg.hit_entry   <= hit_reg;
            res_reg.push_x      <= nx_reg;
            res_reg.push_y      <= ny_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign res       = res_reg;

endmodule

FILE: design/aabb_collision_resolver_top.sv
// Load word: written to the table on acceptance; the block stays ready. Resolve
// word: one table entry per cycle is read over min(active_entries, TABLE_DEPTH)
// entries; a hit ends the scan, a blocking hit then passes ST_DIFF and ST_NORM.
// Result loads when the output is free; the next word is taken the cycle after.
// Reset: synchronous, active low; clears control state and cfg, not the table.
module aabb_collision_resolver_top #(
    parameter int TABLE_DEPTH = 128
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // entry_index, entry_x, entry_y, entry_blocks, entry_overlaps,
    // mover_x, mover_y, speed_x, speed_y, axis
    input  logic [aabb_cr_pkg::S_TDATA_W-1:0]     s_tdata,
    // command
    input  logic [aabb_cr_pkg::S_TUSER_W-1:0]     s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // out_x, out_y, out_speed_x, out_speed_y, hit_entry, push_x, push_y
    output logic [aabb_cr_pkg::M_TDATA_W-1:0]     m_tdata,
    // hit_kind
    output logic [aabb_cr_pkg::M_TUSER_W-1:0]     m_tuser,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [aabb_cr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [aabb_cr_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import aabb_cr_pkg::*;

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    cfg_t   cfg_reg, cfg_next;
    req_t   req;
    res_t   res;
    logic   wr_en, rd_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    entry_t wr_data, rd_data;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_ACTIVE_ENTRIES: cfg_next.active_entries = cfg_data;
                CFG_MOVER_SIZE:     cfg_next.mover_size     = cfg_data;
                CFG_OBSTACLE_SIZE:  cfg_next.obstacle_size  = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.active_entries <= RST_ACTIVE_ENTRIES;
            cfg_reg.mover_size     <= RST_MOVER_SIZE;
            cfg_reg.obstacle_size  <= RST_OBSTACLE_SIZE;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign req.command        = s_tuser[0];
    assign req.entry_index    = s_tdata[6:0];
    assign req.entry.x        = s_tdata[22:7];
    assign req.entry.y        = s_tdata[38:23];
    assign req.entry.blocks   = s_tdata[39];
    assign req.entry.overlaps = s_tdata[40];
    assign req.mover_x        = s_tdata[56:41];
    assign req.mover_y        = s_tdata[72:57];
    assign req.speed_x        = s_tdata[88:73];
    assign req.speed_y        = s_tdata[104:89];
    assign req.axis           = s_tdata[105];

    aabb_cr_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    aabb_cr_scan #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .req       (req),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .res       (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    assign m_tdata = {5'b0, res.push_y, res.push_x, res.hit_entry,
                      res.out_speed_y, res.out_speed_x, res.out_y, res.out_x};
    assign m_tuser = res.hit_kind;

endmodule
